@@ rtl/core/hacd_pkg.sv @@
// shared types and constants of the hex ascii command deframer
package hacd_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int POS_W         = 5;
    localparam int CNT_W         = 4;

    localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(2 + 2 * PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] ID_LAST    = POS_W'(2);
    localparam logic [POS_W-1:0] ID_HIGH    = POS_W'(1);
    localparam logic [POS_W-1:0] PAY_FIRST  = POS_W'(3);

    localparam logic [7:0] START_CHAR      = 8'h23;
    localparam logic [7:0] PAD_CHAR        = 8'h58;
    localparam logic [7:0] DIGIT_BASE      = 8'h30;
    localparam logic [7:0] LETTER_BASE     = 8'h37;
    localparam logic [7:0] CAMERA_ID_RESET = 8'd45;
    localparam logic [7:0] SKIP_MAX        = 8'hFF;

    // queue between classifier and frame parser
    localparam int QDEPTH  = 4;
    localparam int QADDR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_PAD_END  = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    // one classified received character
    typedef struct packed {
        logic       is_hex;
        logic       is_pad;
        logic       is_start;
        logic [3:0] nibble;
    } char_t;

endpackage

@@ rtl/core/hacd_front.sv @@
// front end: classifies each received byte and holds it for the queue
module hacd_front
    import hacd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       q_valid,
    input  logic       q_ready,
    output char_t      q_item
);

    logic  vld_reg;
    logic  vld_next;
    char_t item_reg;
    char_t item_next;
    char_t cls;

    always_comb begin
        cls          = '0;
        cls.is_start = (s_rx_byte == START_CHAR);
        cls.is_pad   = (s_rx_byte == PAD_CHAR);
        if (s_rx_byte inside {[8'h30:8'h39]}) begin
            cls.is_hex = 1'b1;
            cls.nibble = 4'(s_rx_byte - DIGIT_BASE);
        end else if (s_rx_byte inside {[8'h41:8'h46]}) begin
            cls.is_hex = 1'b1;
            cls.nibble = 4'(s_rx_byte - LETTER_BASE);
        end
    end

    assign s_ready = !vld_reg || q_ready;

    always_comb begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (s_valid && s_ready) begin
            vld_next  = 1'b1;
            item_next = cls;
        end else if (q_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        item_reg <= item_next;
    end

    assign q_valid = vld_reg;
    assign q_item  = item_reg;

endmodule

@@ rtl/core/hacd_queue.sv @@
// small fifo of classified characters between front and back
module hacd_queue
    import hacd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  char_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output char_t out_item
);

    char_t              mem [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg;
    logic [QADDR_W-1:0] wr_ptr_next;
    logic [QADDR_W-1:0] rd_ptr_reg;
    logic [QADDR_W-1:0] rd_ptr_next;
    logic [QADDR_W:0]   count_reg;
    logic [QADDR_W:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != (QADDR_W+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/core/hacd_back.sv @@
// back end: frame parser, section decode and result register
module hacd_back
    import hacd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           camera_id,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  char_t                in_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_command_id,
    output logic [PAYLOAD_W-1:0] m_payload,
    output logic [1:0]           m_id_status,
    output logic [1:0]           m_payload_status,
    output logic [CNT_W-1:0]     m_payload_count,
    output logic                 m_to_camera,
    output logic [7:0]           m_skipped_bytes
);

    logic [POS_W-1:0]     pos_reg,    pos_next;
    logic [3:0]           hold_reg,   hold_next;
    logic [7:0]           id_reg,     id_next;
    logic [PAYLOAD_W-1:0] pay_reg,    pay_next;
    status_t              id_st_reg,  id_st_next;
    status_t              pay_st_reg, pay_st_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [7:0]           skip_reg,   skip_next;
    logic                 emit;

    logic                 mv_reg,   mv_next;
    logic [7:0]           mid_reg,  mid_next;
    logic [PAYLOAD_W-1:0] mpay_reg, mpay_next;
    status_t              mids_reg, mids_next;
    status_t              mps_reg,  mps_next;
    logic [CNT_W-1:0]     mcnt_reg, mcnt_next;
    logic                 mcam_reg, mcam_next;
    logic [7:0]           mskp_reg, mskp_next;

    logic [POS_W-1:0]     k;
    logic [2:0]           lane;
    logic                 take;

    assign in_ready = !mv_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign k        = pos_reg - PAY_FIRST;
    assign lane     = k[3:1];

    always_comb begin
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        id_next     = id_reg;
        pay_next    = pay_reg;
        id_st_next  = id_st_reg;
        pay_st_next = pay_st_reg;
        cnt_next    = cnt_reg;
        skip_next   = skip_reg;
        emit        = 1'b0;

        if (take) begin
            if (pos_reg == '0) begin
                // hunting for the start character
                if (in_item.is_start) begin
                    hold_next   = '0;
                    id_next     = '0;
                    pay_next    = '0;
                    id_st_next  = ST_COMPLETE;
                    pay_st_next = ST_COMPLETE;
                    cnt_next    = '0;
                    pos_next    = POS_W'(1);
                end else if (skip_reg != SKIP_MAX) begin
                    skip_next = skip_reg + 1'b1;
                end
            end else begin
                if (pos_reg <= ID_LAST) begin
                    if (id_st_reg == ST_COMPLETE) begin
                        if (pos_reg == ID_HIGH) begin
                            if (in_item.is_hex) begin
                                hold_next = in_item.nibble;
                                id_next   = {in_item.nibble, 4'h0};
                            end else begin
                                id_st_next = in_item.is_pad ? ST_PAD_END : ST_INVALID;
                            end
                        end else begin
                            if (in_item.is_hex) begin
                                id_next = {hold_reg, in_item.nibble};
                            end else begin
                                id_st_next = ST_INVALID;
                            end
                        end
                    end
                end else if (pay_st_reg == ST_COMPLETE) begin
                    if (!k[0]) begin
                        if (in_item.is_hex) begin
                            hold_next = in_item.nibble;
                            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                                if (lane == 3'(i)) begin
                                    pay_next[PAYLOAD_W-8*i-1 -: 4] = in_item.nibble;
                                end
                            end
                        end else begin
                            pay_st_next = in_item.is_pad ? ST_PAD_END : ST_INVALID;
                        end
                    end else begin
                        if (in_item.is_hex) begin
                            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                                if (lane == 3'(i)) begin
                                    pay_next[PAYLOAD_W-8*i-5 -: 4] = in_item.nibble;
                                end
                            end
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            pay_st_next = ST_INVALID;
                        end
                    end
                end

                if (pos_reg < FRAME_LAST) begin
                    pos_next = pos_reg + 1'b1;
                end else begin
                    emit      = 1'b1;
                    pos_next  = '0;
                    skip_next = '0;
                end
            end
        end
    end

    // result register, refilled as soon as the consumer takes the last one
    always_comb begin
        mv_next   = mv_reg;
        mid_next  = mid_reg;
        mpay_next = mpay_reg;
        mids_next = mids_reg;
        mps_next  = mps_reg;
        mcnt_next = mcnt_reg;
        mcam_next = mcam_reg;
        mskp_next = mskp_reg;
        if (emit) begin
            mv_next   = 1'b1;
            mid_next  = id_next;
            mpay_next = pay_next;
            mids_next = id_st_next;
            mps_next  = pay_st_next;
            mcnt_next = (pay_st_next == ST_INVALID) ? '0 : cnt_next;
            mcam_next = (id_next == camera_id);
            mskp_next = skip_reg;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            hold_reg   <= '0;
            id_reg     <= '0;
            pay_reg    <= '0;
            id_st_reg  <= ST_COMPLETE;
            pay_st_reg <= ST_COMPLETE;
            cnt_reg    <= '0;
            skip_reg   <= '0;
            mv_reg     <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            hold_reg   <= hold_next;
            id_reg     <= id_next;
            pay_reg    <= pay_next;
            id_st_reg  <= id_st_next;
            pay_st_reg <= pay_st_next;
            cnt_reg    <= cnt_next;
            skip_reg   <= skip_next;
            mv_reg     <= mv_next;
        end
        mid_reg  <= mid_next;
        mpay_reg <= mpay_next;
        mids_reg <= mids_next;
        mps_reg  <= mps_next;
        mcnt_reg <= mcnt_next;
        mcam_reg <= mcam_next;
        mskp_reg <= mskp_next;
    end

    assign m_valid          = mv_reg;
    assign m_command_id     = mid_reg;
    assign m_payload        = mpay_reg;
    assign m_id_status      = mids_reg;
    assign m_payload_status = mps_reg;
    assign m_payload_count  = mcnt_reg;
    assign m_to_camera      = mcam_reg;
    assign m_skipped_bytes  = mskp_reg;

endmodule

@@ rtl/core/hex_ascii_command_deframer.sv @@
// Hex ascii command deframer: takes one received byte per transaction and parses 19-byte
// frames ('#', two hex characters of command id, sixteen hex characters of payload),
// giving one result transaction per frame. One byte is accepted per clock cycle as long as
// the result side keeps up; a byte passes the classifier register, a four-entry queue and
// the frame parser, and the last byte of a frame sets m_valid through the result register.
// While a result waits on m_ready, the parser holds and the queue and the classifier
// register absorb up to five more bytes. The camera command register may only be written
// while no frame is open.
module hex_ascii_command_deframer
    import hacd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_command_id,
    output logic [PAYLOAD_W-1:0] m_payload,
    output logic [1:0]           m_id_status,
    output logic [1:0]           m_payload_status,
    output logic [CNT_W-1:0]     m_payload_count,
    output logic                 m_to_camera,
    output logic [7:0]           m_skipped_bytes
);

    logic [7:0] camera_id_reg;
    logic [7:0] camera_id_next;
    logic       fq_valid;
    logic       fq_ready;
    char_t      fq_item;
    logic       qb_valid;
    logic       qb_ready;
    char_t      qb_item;

    assign cfg_ready      = 1'b1;
    assign camera_id_next = (cfg_valid && cfg_ready) ? cfg_data : camera_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_id_reg <= CAMERA_ID_RESET;
        end else begin
            camera_id_reg <= camera_id_next;
        end
    end

    hacd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    hacd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    hacd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .camera_id        (camera_id_reg),
        .in_valid         (qb_valid),
        .in_ready         (qb_ready),
        .in_item          (qb_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command_id     (m_command_id),
        .m_payload        (m_payload),
        .m_id_status      (m_id_status),
        .m_payload_status (m_payload_status),
        .m_payload_count  (m_payload_count),
        .m_to_camera      (m_to_camera),
        .m_skipped_bytes  (m_skipped_bytes)
    );

endmodule

@@ bench/deframer_checker.sv @@
// frame predictor and result checker for the hex ascii command deframer
`timescale 1ns / 100ps

module deframer_checker
    import hacd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [7:0]           m_command_id,
    input  logic [PAYLOAD_W-1:0] m_payload,
    input  logic [1:0]           m_id_status,
    input  logic [1:0]           m_payload_status,
    input  logic [CNT_W-1:0]     m_payload_count,
    input  logic                 m_to_camera,
    input  logic [7:0]           m_skipped_bytes,
    output int                   mismatch_count,
    output int                   frames_pending
);

    localparam logic [4:0] NOT_HEX    = 5'd16;
    localparam int         MAX_REPORT = 10;

    typedef struct packed {
        logic [7:0]           command_id;
        logic [PAYLOAD_W-1:0] payload;
        status_t              id_status;
        status_t              payload_status;
        logic [CNT_W-1:0]     payload_count;
        logic                 to_camera;
        logic [7:0]           skipped_bytes;
    } frame_result_t;

    frame_result_t expected_frames[$];

    // predicted state of the parser
    logic [7:0]           camera_id;
    logic [POS_W-1:0]     frame_pos;
    logic [3:0]           nibble_hold;
    logic [7:0]           id_acc;
    logic [PAYLOAD_W-1:0] payload_acc;
    status_t              id_st;
    status_t              pay_st;
    logic [CNT_W-1:0]     bytes_done;
    logic [7:0]           skip_count;

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return NOT_HEX;
    endfunction

    task automatic absorb_byte(input logic [7:0] c);
        logic [4:0]       nib;
        logic [POS_W-1:0] k;
        int               base;
        frame_result_t    r;
        nib = digit_value(c);
        if (frame_pos == '0) begin
            if (c == START_CHAR) begin
                nibble_hold = '0;
                id_acc      = '0;
                payload_acc = '0;
                id_st       = ST_COMPLETE;
                pay_st      = ST_COMPLETE;
                bytes_done  = '0;
                frame_pos   = ID_HIGH;
            end else if (skip_count != SKIP_MAX) begin
                skip_count = skip_count + 8'd1;
            end
            return;
        end
        if (frame_pos <= ID_LAST) begin
            if (id_st == ST_COMPLETE) begin
                if (frame_pos == ID_HIGH) begin
                    if (nib != NOT_HEX) begin
                        nibble_hold = nib[3:0];
                        id_acc      = {nib[3:0], 4'h0};
                    end else begin
                        id_st = (c == PAD_CHAR) ? ST_PAD_END : ST_INVALID;
                    end
                end else if (nib != NOT_HEX) begin
                    id_acc = {nibble_hold, nib[3:0]};
                end else begin
                    id_st = ST_INVALID;
                end
            end
        end else if (pay_st == ST_COMPLETE) begin
            k    = frame_pos - PAY_FIRST;
            base = PAYLOAD_W - 8 * (int'(k >> 1) + 1);
            if (!k[0]) begin
                if (nib != NOT_HEX)
                    payload_acc[base+4 +: 4] = nib[3:0];
                else
                    pay_st = (c == PAD_CHAR) ? ST_PAD_END : ST_INVALID;
            end else if (nib != NOT_HEX) begin
                payload_acc[base +: 4] = nib[3:0];
                bytes_done = bytes_done + 1'b1;
            end else begin
                pay_st = ST_INVALID;
            end
        end
        if (frame_pos != FRAME_LAST) begin
            frame_pos = frame_pos + 1'b1;
            return;
        end
        r.command_id     = id_acc;
        r.payload        = payload_acc;
        r.id_status      = id_st;
        r.payload_status = pay_st;
        r.payload_count  = (pay_st == ST_INVALID) ? '0 : bytes_done;
        r.to_camera      = (id_acc == camera_id);
        r.skipped_bytes  = skip_count;
        expected_frames.push_back(r);
        frame_pos  = '0;
        skip_count = '0;
    endtask

    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (!aresetn) begin
            camera_id   = CAMERA_ID_RESET;
            frame_pos   = '0;
            nibble_hold = '0;
            id_acc      = '0;
            payload_acc = '0;
            id_st       = ST_COMPLETE;
            pay_st      = ST_COMPLETE;
            bytes_done  = '0;
            skip_count  = '0;
            expected_frames.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                camera_id = cfg_data;
            if (m_valid && m_ready) begin
                got.command_id     = m_command_id;
                got.payload        = m_payload;
                got.id_status      = status_t'(m_id_status);
                got.payload_status = status_t'(m_payload_status);
                got.payload_count  = m_payload_count;
                got.to_camera      = m_to_camera;
                got.skipped_bytes  = m_skipped_bytes;
                if (expected_frames.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("%0t: result transaction with none expected, id %h pay %h",
                                 $time, got.command_id, got.payload);
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORT) begin
                            $display("%0t: exp id %h pay %h st %0d/%0d cnt %0d cam %0b skp %0d",
                                     $time, want.command_id, want.payload, want.id_status,
                                     want.payload_status, want.payload_count, want.to_camera,
                                     want.skipped_bytes);
                            $display("%0t: act id %h pay %h st %0d/%0d cnt %0d cam %0b skp %0d",
                                     $time, got.command_id, got.payload, got.id_status,
                                     got.payload_status, got.payload_count, got.to_camera,
                                     got.skipped_bytes);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                absorb_byte(s_rx_byte);
        end
        frames_pending <= expected_frames.size();
    end

endmodule

@@ bench/testbench.sv @@
// stimulus and verdict for the hex ascii command deframer
`timescale 1ns / 100ps

module testbench;
    import hacd_pkg::*;

    localparam int NBODY        = 2 + 2 * PAYLOAD_BYTES;
    localparam int PHASES       = 5;
    localparam int PHASE_BYTES  = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 200000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_command_id;
    logic [PAYLOAD_W-1:0] m_payload;
    logic [1:0]           m_id_status;
    logic [1:0]           m_payload_status;
    logic [CNT_W-1:0]     m_payload_count;
    logic                 m_to_camera;
    logic [7:0]           m_skipped_bytes;

    int   mismatch_count;
    int   frames_pending;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   hold_left = 0;
    logic hold_request = 1'b0;
    logic steady = 1'b0;
    logic [7:0] camera_setting = CAMERA_ID_RESET;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    hex_ascii_command_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command_id     (m_command_id),
        .m_payload        (m_payload),
        .m_id_status      (m_id_status),
        .m_payload_status (m_payload_status),
        .m_payload_count  (m_payload_count),
        .m_to_camera      (m_to_camera),
        .m_skipped_bytes  (m_skipped_bytes)
    );

    deframer_checker watch (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command_id     (m_command_id),
        .m_payload        (m_payload),
        .m_id_status      (m_id_status),
        .m_payload_status (m_payload_status),
        .m_payload_count  (m_payload_count),
        .m_to_camera      (m_to_camera),
        .m_skipped_bytes  (m_skipped_bytes),
        .mismatch_count   (mismatch_count),
        .frames_pending   (frames_pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("testbench: errors");
        $finish;
    end

    // result side: random stalls, none while steady, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        return (n < 10) ? 8'("0" + n) : 8'("A" + n - 10);
    endfunction

    // leaves valid high after the transaction; the next call or settle() decides
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            if (b == START_CHAR)
                b = b ^ 8'h01;
            send_byte(b);
        end
    endtask

    task automatic send_frame_text(input string body);
        send_byte(START_CHAR);
        for (int i = 0; i < body.len(); i++)
            send_byte(body[i]);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        // let the pending count see the last transaction
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        // bytes that end no frame may still sit in the pipeline
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [7:0]           body [NBODY];
        logic [7:0]           frame_id;
        logic [PAYLOAD_W-1:0] pay_bits;
        int                   phase_start;
        int                   kind;
        int                   pos;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames under the reset camera id
        send_noise(3);
        send_frame_text("2D0123456789ABCDEF");
        send_frame_text({"000000", "000000", "000000"});
        send_frame_text({"FFFFFF", "FFFFFF", "FFFFFF"});
        send_frame_text("X50123456789ABCDEF");
        send_frame_text("4X0123456789ABCDEF");
        send_frame_text("XX0123456789ABCDEF");
        send_frame_text("7E0123abcdef456789");
        send_frame_text("1A01#3456789ABCDEF");
        send_frame_text({"2C010203", "XXXXX", "XXXXX"});
        send_frame_text({"2B", "XXXXXXXX", "XXXXXXXX"});
        send_frame_text("2A01020X0405060708");

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1:       camera_setting = 8'h00;
                    2:       camera_setting = 8'hFF;
                    default: camera_setting = 8'($urandom);
                endcase
                cfg_valid <= 1'b1;
                cfg_data  <= camera_setting;
                do @(posedge aclk); while (!cfg_ready);
                cfg_valid <= 1'b0;
            end
            if (p == 1)
                send_noise(280);
            if (p == 2)
                hold_request = 1'b1;
            steady = (p == 3);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (bytes_sent - phase_start >= PHASE_BYTES / 2)
                    steady = 1'b0;
                send_noise(($urandom_range(99) < 3) ? $urandom_range(300, 250)
                                                    : $urandom_range(4));
                frame_id = ($urandom_range(99) < 20) ? camera_setting : 8'($urandom);
                pay_bits = {$urandom, $urandom};
                body[0] = nibble_char(frame_id[7:4]);
                body[1] = nibble_char(frame_id[3:0]);
                for (int j = 0; j < 2 * PAYLOAD_BYTES; j++)
                    body[2+j] = nibble_char(pay_bits[PAYLOAD_W-4-4*j +: 4]);
                kind = $urandom_range(99);
                if (kind >= 60 && kind < 80) begin
                    // pad on a high-nibble place, the tail all pad or left as hex
                    pos = ($urandom_range(3) == 0) ? 0 : 2 + 2 * $urandom_range(PAYLOAD_BYTES - 1);
                    body[pos] = PAD_CHAR;
                    if ($urandom_range(1))
                        for (int j = pos + 1; j < NBODY; j++)
                            body[j] = PAD_CHAR;
                end else if (kind >= 80) begin
                    repeat ($urandom_range(2, 1)) begin
                        pos = $urandom_range(NBODY - 1);
                        case ($urandom_range(3))
                            0:       body[pos] = 8'("a" + $urandom_range(5));
                            1:       body[pos] = START_CHAR;
                            2:       body[pos] = PAD_CHAR;
                            default: body[pos] = 8'($urandom);
                        endcase
                    end
                end
                send_byte(START_CHAR);
                for (int j = 0; j < NBODY; j++)
                    send_byte(body[j]);
            end
        end
        settle();

        if (mismatch_count == 0 && frames_pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/hacd_pkg.sv
rtl/core/hacd_front.sv
rtl/core/hacd_queue.sv
rtl/core/hacd_back.sv
rtl/core/hex_ascii_command_deframer.sv
bench/deframer_checker.sv
bench/testbench.sv
